[hdl/npt_pkg.sv]
// Shared definitions for the nearest-point-on-triangle pipeline.
// Region codes and the width rules for the exact intermediate results.
// No dependencies.
package npt_pkg;

	typedef logic [2:0] region_t;

	// Bit 2 outside CA, bit 1 outside BC, bit 0 outside AB.
	localparam region_t REG_INSIDE = 3'd0;
	localparam region_t REG_AB     = 3'd1;
	localparam region_t REG_BC     = 3'd2;
	localparam region_t REG_VB     = 3'd3;
	localparam region_t REG_CA     = 3'd4;
	localparam region_t REG_VA     = 3'd5;
	localparam region_t REG_VC     = 3'd6;
	localparam region_t REG_NONE   = 3'd7;

	// Width of the edge-plane distances for a given coordinate width.
	function automatic int dist_width(input int cw);
		return 4 * cw + 8;
	endfunction

	// Width of the edge projection dot products.
	function automatic int proj_width(input int cw);
		return 2 * cw + 4;
	endfunction

endpackage

[hdl/npt_geom.sv]
// Geometry front end: edge vectors, normal, edge planes and distances.
// Four pipeline stages; depends on npt_pkg.
module npt_geom #(
	parameter int CW = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [CW-1:0]                      vtx [3][3],
	input  logic signed [CW-1:0]                      pt [3],
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [npt_pkg::dist_width(CW)-1:0] edge_dist [3],
	output logic signed [npt_pkg::proj_width(CW)-1:0] proj [6],
	output logic signed [CW-1:0]                      vtx_out [3][3]
);
	import npt_pkg::*;

	localparam int DW  = CW + 1;
	localparam int NW  = 2 * DW + 1;
	localparam int EW  = NW + DW + 1;
	localparam int DDW = dist_width(CW);
	localparam int PW  = proj_width(CW);

	// One component of u x v, given the other two components of each.
	function automatic logic signed [NW-1:0] ncomp(input logic signed [DW-1:0] uj, uk, vj, vk);
		logic signed [2*DW-1:0] p0, p1;
		p0 = uj * vk;
		p1 = uk * vj;
		return NW'(p0) - NW'(p1);
	endfunction

	function automatic logic signed [EW-1:0] xcomp(input logic signed [NW-1:0] nj, nk,
			input logic signed [DW-1:0] ej, ek);
		logic signed [NW+DW-1:0] p0, p1;
		p0 = nj * ek;
		p1 = nk * ej;
		return EW'(p0) - EW'(p1);
	endfunction

	function automatic logic signed [PW-1:0] dotp(input logic signed [DW-1:0] u0, u1, u2,
			v0, v1, v2);
		logic signed [2*DW-1:0] p0, p1, p2;
		p0 = u0 * v0;
		p1 = u1 * v1;
		p2 = u2 * v2;
		return PW'(p0) + PW'(p1) + PW'(p2);
	endfunction

	function automatic logic signed [DDW-1:0] dote(input logic signed [DW-1:0] u0, u1, u2,
			input logic signed [EW-1:0] v0, v1, v2);
		logic signed [EW+DW-1:0] p0, p1, p2;
		p0 = u0 * v0;
		p1 = u1 * v1;
		p2 = u2 * v2;
		return DDW'(p0) + DDW'(p1) + DDW'(p2);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [DW-1:0]  ab_s1 [3], bc_s1 [3], ca_s1 [3], ap_s1 [3], bp_s1 [3], cp_s1 [3];
	logic signed [CW-1:0]  vtx_s1 [3][3];
	logic signed [NW-1:0]  n_s2 [3];
	logic signed [DW-1:0]  ab_s2 [3], bc_s2 [3], ca_s2 [3], ap_s2 [3], bp_s2 [3], cp_s2 [3];
	logic signed [PW-1:0]  pj_s2 [6];
	logic signed [CW-1:0]  vtx_s2 [3][3];
	logic signed [EW-1:0]  nab_s3 [3], nbc_s3 [3], nca_s3 [3];
	logic signed [DW-1:0]  ap_s3 [3], bp_s3 [3], cp_s3 [3];
	logic signed [PW-1:0]  pj_s3 [6];
	logic signed [CW-1:0]  vtx_s3 [3][3];
	logic signed [DDW-1:0] d_s4 [3];
	logic signed [PW-1:0]  pj_s4 [6];
	logic signed [CW-1:0]  vtx_s4 [3][3];

	logic signed [NW-1:0]  n_d [3];
	logic signed [EW-1:0]  nab_d [3], nbc_d [3], nca_d [3];

	// A stage loads when it is empty or its successor moves on.
	assign en_s4     = !v_s4 || out_ready;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign in_ready  = en_s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: edge vectors and vectors from each vertex to the point.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 3; i++) begin
				ab_s1[i] <= DW'(vtx[1][i]) - DW'(vtx[0][i]);
				bc_s1[i] <= DW'(vtx[2][i]) - DW'(vtx[1][i]);
				ca_s1[i] <= DW'(vtx[0][i]) - DW'(vtx[2][i]);
				ap_s1[i] <= DW'(pt[i]) - DW'(vtx[0][i]);
				bp_s1[i] <= DW'(pt[i]) - DW'(vtx[1][i]);
				cp_s1[i] <= DW'(pt[i]) - DW'(vtx[2][i]);
				for (int v = 0; v < 3; v++) vtx_s1[v][i] <= vtx[v][i];
			end
		end
	end

	// Cross product components for the normal and the edge planes of AB, BC and CA.
	for (genvar gi = 0; gi < 3; gi++) begin : g_cross
		localparam int J = (gi + 1) % 3;
		localparam int K = (gi + 2) % 3;
		assign n_d[gi]   = ncomp(ab_s1[J], ab_s1[K], bc_s1[J], bc_s1[K]);
		assign nab_d[gi] = xcomp(n_s2[J], n_s2[K], ab_s2[J], ab_s2[K]);
		assign nbc_d[gi] = xcomp(n_s2[J], n_s2[K], bc_s2[J], bc_s2[K]);
		assign nca_d[gi] = xcomp(n_s2[J], n_s2[K], ca_s2[J], ca_s2[K]);
	end

	// Stage 2: normal N = AB x BC and the edge projection dot products.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int i = 0; i < 3; i++) begin
				n_s2[i]  <= n_d[i];
				ab_s2[i] <= ab_s1[i];
				bc_s2[i] <= bc_s1[i];
				ca_s2[i] <= ca_s1[i];
				ap_s2[i] <= ap_s1[i];
				bp_s2[i] <= bp_s1[i];
				cp_s2[i] <= cp_s1[i];
				for (int v = 0; v < 3; v++) vtx_s2[v][i] <= vtx_s1[v][i];
			end
			pj_s2[0] <= dotp(bp_s1[0], bp_s1[1], bp_s1[2], ab_s1[0], ab_s1[1], ab_s1[2]);
			pj_s2[1] <= dotp(ap_s1[0], ap_s1[1], ap_s1[2], ab_s1[0], ab_s1[1], ab_s1[2]);
			pj_s2[2] <= dotp(cp_s1[0], cp_s1[1], cp_s1[2], bc_s1[0], bc_s1[1], bc_s1[2]);
			pj_s2[3] <= dotp(bp_s1[0], bp_s1[1], bp_s1[2], bc_s1[0], bc_s1[1], bc_s1[2]);
			pj_s2[4] <= dotp(ap_s1[0], ap_s1[1], ap_s1[2], ca_s1[0], ca_s1[1], ca_s1[2]);
			pj_s2[5] <= dotp(cp_s1[0], cp_s1[1], cp_s1[2], ca_s1[0], ca_s1[1], ca_s1[2]);
		end
	end

	// Stage 3: inward edge plane normals N x edge.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < 3; i++) begin
				nab_s3[i] <= nab_d[i];
				nbc_s3[i] <= nbc_d[i];
				nca_s3[i] <= nca_d[i];
				ap_s3[i]  <= ap_s2[i];
				bp_s3[i]  <= bp_s2[i];
				cp_s3[i]  <= cp_s2[i];
				for (int v = 0; v < 3; v++) vtx_s3[v][i] <= vtx_s2[v][i];
			end
			for (int k = 0; k < 6; k++) pj_s3[k] <= pj_s2[k];
		end
	end

	// Stage 4: signed distances of P from the edge planes of AB, BC and CA.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			d_s4[0] <= dote(ap_s3[0], ap_s3[1], ap_s3[2], nab_s3[0], nab_s3[1], nab_s3[2]);
			d_s4[1] <= dote(bp_s3[0], bp_s3[1], bp_s3[2], nbc_s3[0], nbc_s3[1], nbc_s3[2]);
			d_s4[2] <= dote(cp_s3[0], cp_s3[1], cp_s3[2], nca_s3[0], nca_s3[1], nca_s3[2]);
			for (int k = 0; k < 6; k++) pj_s4[k] <= pj_s3[k];
			for (int i = 0; i < 3; i++)
				for (int v = 0; v < 3; v++) vtx_s4[v][i] <= vtx_s3[v][i];
		end
	end

	assign edge_dist = d_s4;
	assign proj = pj_s4;
	assign vtx_out = vtx_s4;

endmodule

[hdl/npt_weight.sv]
// Region classification, weight selection and weighted vertex sums.
// Three pipeline stages; depends on npt_pkg.
module npt_weight #(
	parameter int CW = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic signed [npt_pkg::dist_width(CW)-1:0]     edge_dist [3],
	input  logic signed [npt_pkg::proj_width(CW)-1:0]     proj [6],
	input  logic signed [CW-1:0]                          vtx [3][3],
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic signed [npt_pkg::dist_width(CW)+CW+1:0]  num [3],
	output logic [npt_pkg::dist_width(CW):0]              wsum,
	output logic                                          degen,
	output npt_pkg::region_t                              region,
	output logic signed [CW-1:0]                          va [3]
);
	import npt_pkg::*;

	localparam int DDW = dist_width(CW);
	localparam int PRW = DDW + CW;
	localparam int MW  = PRW + 2;

	logic v_s5, v_s6, v_s7;
	logic en_s5, en_s6, en_s7;

	logic signed [DDW-1:0] ws [3];
	logic [DDW-2:0]        w_s5 [3];
	region_t               reg_s5, reg_s6, reg_s7;
	logic signed [CW-1:0]  vtx_s5 [3][3];
	logic signed [PRW-1:0] pr_s6 [3][3];
	logic [DDW:0]          wsum_s6, wsum_s7;
	logic signed [CW-1:0]  va_s6 [3], va_s7 [3];
	logic signed [MW-1:0]  num_s7 [3];
	logic                  deg_s7;
	region_t               reg_d;

	assign en_s7     = !v_s7 || out_ready;
	assign en_s6     = !v_s6 || en_s7;
	assign en_s5     = !v_s5 || en_s6;
	assign in_ready  = en_s5;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Region code from the distance signs, then the weights it selects.
	assign reg_d = {edge_dist[2][DDW-1], edge_dist[1][DDW-1], edge_dist[0][DDW-1]};

	always_comb begin
		ws[0] = '0;
		ws[1] = '0;
		ws[2] = '0;
		unique case (reg_d)
			REG_INSIDE: begin
				ws[0] = edge_dist[1];
				ws[1] = edge_dist[2];
				ws[2] = edge_dist[0];
			end
			REG_AB: begin
				ws[0] = -DDW'(proj[0]);
				ws[1] = DDW'(proj[1]);
			end
			REG_BC: begin
				ws[1] = -DDW'(proj[2]);
				ws[2] = DDW'(proj[3]);
			end
			REG_CA: begin
				ws[2] = -DDW'(proj[4]);
				ws[0] = DDW'(proj[5]);
			end
			REG_VB: ws[1] = DDW'(1);
			REG_VA: ws[0] = DDW'(1);
			REG_VC: ws[2] = DDW'(1);
			REG_NONE: begin
				ws[0] = DDW'(1);
				ws[1] = DDW'(1);
				ws[2] = DDW'(1);
			end
		endcase
	end

	// Stage 5: clamp negative weights to zero.
	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int v = 0; v < 3; v++) begin
				w_s5[v] <= ws[v][DDW-1] ? '0 : ws[v][DDW-2:0];
				for (int i = 0; i < 3; i++) vtx_s5[v][i] <= vtx[v][i];
			end
			reg_s5 <= reg_d;
		end
	end

	// Stage 6: weight sum and the nine weight-by-coordinate products.
	always_ff @(posedge clk) begin
		if (en_s6) begin
			wsum_s6 <= (DDW+1)'(w_s5[0]) + (DDW+1)'(w_s5[1]) + (DDW+1)'(w_s5[2]);
			for (int v = 0; v < 3; v++)
				for (int i = 0; i < 3; i++)
					pr_s6[v][i] <= $signed({1'b0, w_s5[v]}) * vtx_s5[v][i];
			for (int i = 0; i < 3; i++) va_s6[i] <= vtx_s5[0][i];
			reg_s6 <= reg_s5;
		end
	end

	// Stage 7: numerators per axis and the zero weight sum check.
	always_ff @(posedge clk) begin
		if (en_s7) begin
			for (int i = 0; i < 3; i++) begin
				num_s7[i] <= MW'(pr_s6[0][i]) + MW'(pr_s6[1][i]) + MW'(pr_s6[2][i]);
				va_s7[i]  <= va_s6[i];
			end
			wsum_s7 <= wsum_s6;
			deg_s7  <= (wsum_s6 == '0);
			reg_s7  <= reg_s6;
		end
	end

	assign num    = num_s7;
	assign wsum   = wsum_s7;
	assign degen  = deg_s7;
	assign region = reg_s7;
	assign va     = va_s7;

endmodule

[hdl/npt_div.sv]
// Pipelined restoring divider: rounds num / wsum to nearest, ties away.
// One prepare stage then one quotient bit per stage; depends on npt_pkg.
module npt_div #(
	parameter int CW = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic signed [npt_pkg::dist_width(CW)+CW+1:0] num [3],
	input  logic [npt_pkg::dist_width(CW):0]             wsum,
	input  logic                                         degen,
	input  npt_pkg::region_t                             region,
	input  logic signed [CW-1:0]                         va [3],
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic [CW:0]                                  quo [3],
	output logic                                         neg [3],
	output logic                                         degen_out,
	output npt_pkg::region_t                             region_out,
	output logic signed [CW-1:0]                         va_out [3]
);
	import npt_pkg::*;

	localparam int DDW = dist_width(CW);
	localparam int MW  = DDW + CW + 2;
	localparam int XW  = MW + 1;
	localparam int QB  = CW + 1;

	logic                 vld_sk [QB+1];
	logic                 en_sk [QB+1];
	logic [XW-1:0]        rem_sk [QB+1][3];
	logic [QB-1:0]        quo_sk [QB+1][3];
	logic                 neg_sk [QB+1][3];
	logic [XW-1:0]        dv_sk [QB+1];
	logic                 deg_sk [QB+1];
	region_t              reg_sk [QB+1];
	logic signed [CW-1:0] va_sk [QB+1][3];
	logic [MW-1:0]        mag [3];

	assign in_ready  = en_sk[0];
	assign out_valid = vld_sk[QB];

	// Magnitude of each numerator; the most negative value fits unsigned.
	always_comb begin
		for (int i = 0; i < 3; i++)
			mag[i] = num[i][MW-1] ? MW'(-num[i]) : MW'(num[i]);
	end

	for (genvar j = 0; j <= QB; j++) begin : g_stage
		// Occupancy and enable for this stage.
		if (j == QB) begin : g_last
			assign en_sk[j] = !vld_sk[j] || out_ready;
		end else begin : g_mid
			assign en_sk[j] = !vld_sk[j] || en_sk[j+1];
		end

		if (j == 0) begin : g_prep
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sk[j] <= 1'b0;
				end else if (en_sk[j]) begin
					vld_sk[j] <= in_valid;
				end
			end

			// Dividend 2|num| + W and divisor 2W give the rounded quotient.
			always_ff @(posedge clk) begin
				if (en_sk[j]) begin
					for (int i = 0; i < 3; i++) begin
						rem_sk[j][i] <= (XW'(mag[i]) << 1) + XW'(wsum);
						quo_sk[j][i] <= '0;
						neg_sk[j][i] <= num[i][MW-1];
						va_sk[j][i]  <= va[i];
					end
					dv_sk[j]  <= XW'(wsum) << 1;
					deg_sk[j] <= degen;
					reg_sk[j] <= region;
				end
			end
		end else begin : g_bit
			localparam int SH = QB - j;
			logic [XW-1:0] trial;
			assign trial = dv_sk[j-1] << SH;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sk[j] <= 1'b0;
				end else if (en_sk[j]) begin
					vld_sk[j] <= vld_sk[j-1];
				end
			end

			// Compare and subtract for quotient bit SH.
			always_ff @(posedge clk) begin
				if (en_sk[j]) begin
					for (int i = 0; i < 3; i++) begin
						if (rem_sk[j-1][i] >= trial) begin
							rem_sk[j][i] <= rem_sk[j-1][i] - trial;
							quo_sk[j][i] <= quo_sk[j-1][i] | (QB'(1) << SH);
						end else begin
							rem_sk[j][i] <= rem_sk[j-1][i];
							quo_sk[j][i] <= quo_sk[j-1][i];
						end
						neg_sk[j][i] <= neg_sk[j-1][i];
						va_sk[j][i]  <= va_sk[j-1][i];
					end
					dv_sk[j]  <= dv_sk[j-1];
					deg_sk[j] <= deg_sk[j-1];
					reg_sk[j] <= reg_sk[j-1];
				end
			end
		end
	end

	assign quo        = quo_sk[QB];
	assign neg        = neg_sk[QB];
	assign degen_out  = deg_sk[QB];
	assign region_out = reg_sk[QB];
	assign va_out     = va_sk[QB];

endmodule

[hdl/nearest_point_on_triangle.sv]
// Nearest point on a 3-D triangle: accepts one request every cycle while the
// result side keeps up and returns the point of triangle ABC closest to P, with
// its region code and a degenerate flag. Each request passes through the four
// geometry stages, three weighting stages, the divider's prepare stage and one
// stage per quotient bit, and the output register. All products are exact.
// Stalls on the result side back up through the pipeline without loss.
module nearest_point_on_triangle #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] az,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] bz,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic signed [COORD_WIDTH-1:0] cz,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic signed [COORD_WIDTH-1:0] qx,
	output logic signed [COORD_WIDTH-1:0] qy,
	output logic signed [COORD_WIDTH-1:0] qz,
	output npt_pkg::region_t              region,
	output logic                          degenerate
);
	import npt_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int DDW = dist_width(CW);
	localparam int PW  = proj_width(CW);
	localparam int MW  = DDW + CW + 2;

	logic signed [CW-1:0]  tri_v [3][3];
	logic signed [CW-1:0]  pt [3];

	logic                  g_valid, g_ready;
	logic signed [DDW-1:0] g_dist [3];
	logic signed [PW-1:0]  g_proj [6];
	logic signed [CW-1:0]  g_vtx [3][3];

	logic                  w_valid, w_ready;
	logic signed [MW-1:0]  w_num [3];
	logic [DDW:0]          w_wsum;
	logic                  w_deg;
	region_t               w_reg;
	logic signed [CW-1:0]  w_va [3];

	logic                  d_valid, d_ready;
	logic [CW:0]           d_quo [3];
	logic                  d_neg [3];
	logic                  d_deg;
	region_t               d_reg;
	logic signed [CW-1:0]  d_va [3];

	logic signed [CW-1:0]  res [3];
	logic                  rsp_valid_q;
	logic signed [CW-1:0]  q_q [3];
	region_t               region_q;
	logic                  deg_q;

	assign tri_v[0][0] = ax;
	assign tri_v[0][1] = ay;
	assign tri_v[0][2] = az;
	assign tri_v[1][0] = bx;
	assign tri_v[1][1] = by;
	assign tri_v[1][2] = bz;
	assign tri_v[2][0] = cx;
	assign tri_v[2][1] = cy;
	assign tri_v[2][2] = cz;
	assign pt[0] = px;
	assign pt[1] = py;
	assign pt[2] = pz;

	npt_geom #(.CW(CW)) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.vtx       (tri_v),
		.pt        (pt),
		.out_valid (g_valid),
		.out_ready (g_ready),
		.edge_dist (g_dist),
		.proj      (g_proj),
		.vtx_out   (g_vtx)
	);

	npt_weight #(.CW(CW)) u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (g_valid),
		.in_ready  (g_ready),
		.edge_dist (g_dist),
		.proj      (g_proj),
		.vtx       (g_vtx),
		.out_valid (w_valid),
		.out_ready (w_ready),
		.num       (w_num),
		.wsum      (w_wsum),
		.degen     (w_deg),
		.region    (w_reg),
		.va        (w_va)
	);

	npt_div #(.CW(CW)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (w_valid),
		.in_ready   (w_ready),
		.num        (w_num),
		.wsum       (w_wsum),
		.degen      (w_deg),
		.region     (w_reg),
		.va         (w_va),
		.out_valid  (d_valid),
		.out_ready  (d_ready),
		.quo        (d_quo),
		.neg        (d_neg),
		.degen_out  (d_deg),
		.region_out (d_reg),
		.va_out     (d_va)
	);

	// Apply the sign, saturate, and fall back to vertex A on a zero weight sum.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (d_deg) begin
				res[i] = d_va[i];
			end else if (d_quo[i][CW] || d_quo[i][CW-1]) begin
				res[i] = d_neg[i] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			end else begin
				res[i] = d_neg[i] ? -d_quo[i][CW-1:0] : d_quo[i][CW-1:0];
			end
		end
	end

	// Output register; it takes a new result whenever the current one is gone.
	assign d_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (d_ready) begin
			rsp_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d_ready) begin
			for (int i = 0; i < 3; i++) q_q[i] <= res[i];
			region_q <= d_reg;
			deg_q    <= d_deg;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign qx         = q_q[0];
	assign qy         = q_q[1];
	assign qz         = q_q[2];
	assign region     = region_q;
	assign degenerate = deg_q;

	// Corner and centroid regions always carry a positive weight.
	a_corner_not_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (region == REG_VA || region == REG_VB || region == REG_VC ||
			region == REG_NONE) |-> !degenerate)
		else $error("corner or centroid region flagged degenerate");

	// The request side can only stall when the whole pipeline is backed up.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled while the result side is free");

endmodule

[verif/tb.sv]
// Testbench for nearest_point_on_triangle: directed and random requests with a
// scoreboard that predicts the nearest point with exact wide arithmetic.
// Depends on npt_pkg and the nearest_point_on_triangle RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import npt_pkg::*;

	localparam int CW = 16;
	localparam int LATENCY = CW + 10;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [255:0] wide_t;

	typedef struct {
		coord_t qx, qy, qz;
		region_t region;
		logic degenerate;
	} point_rsp_t;

	int mismatch_count = 0;

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Predicts each nearest-point result and holds them in request order.
	class nearest_point_board;
		point_rsp_t pending[$];

		function wide_t dot3(input wide_t u[3], input wide_t v[3]);
			return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
		endfunction

		function void cross3(output wide_t o[3], input wide_t u[3], input wide_t v[3]);
			o[0] = u[1] * v[2] - u[2] * v[1];
			o[1] = u[2] * v[0] - u[0] * v[2];
			o[2] = u[0] * v[1] - u[1] * v[0];
		endfunction

		// Weighted mean of one coordinate, rounded half away from zero, saturated.
		function coord_t mean_coord(input wide_t wa, wb, wc, wsum, input wide_t a, b, c);
			wide_t num, mag, q;
			logic neg;
			num = wa * a + wb * b + wc * c;
			neg = num < 0;
			mag = neg ? -num : num;
			q = (2 * mag + wsum) / (2 * wsum);
			if (neg) q = -q;
			if (q > 32767) return 16'sh7fff;
			if (q < -32768) return 16'sh8000;
			return coord_t'(q);
		endfunction

		function void note_request(input coord_t in[12]);
			wide_t v[4][3];
			wide_t ap[3], bp[3], cp[3], ab[3], bc[3], ca[3];
			wide_t n[3], nab[3], nbc[3], nca[3];
			wide_t dab, dbc, dca, wa, wb, wc, wsum;
			point_rsp_t r;
			for (int k = 0; k < 4; k++)
				for (int i = 0; i < 3; i++) v[k][i] = in[k * 3 + i];
			for (int i = 0; i < 3; i++) begin
				ap[i] = v[3][i] - v[0][i];
				bp[i] = v[3][i] - v[1][i];
				cp[i] = v[3][i] - v[2][i];
				ab[i] = v[1][i] - v[0][i];
				bc[i] = v[2][i] - v[1][i];
				ca[i] = v[0][i] - v[2][i];
			end
			cross3(n, ab, bc);
			cross3(nab, n, ab);
			cross3(nbc, n, bc);
			cross3(nca, n, ca);
			dab = dot3(ap, nab);
			dbc = dot3(bp, nbc);
			dca = dot3(cp, nca);
			r.region = {dca < 0, dbc < 0, dab < 0};
			wa = 0; wb = 0; wc = 0;
			case (r.region)
				REG_INSIDE: begin wa = dbc; wb = dca; wc = dab; end
				REG_AB: begin wa = -dot3(bp, ab); wb = dot3(ap, ab); end
				REG_BC: begin wb = -dot3(cp, bc); wc = dot3(bp, bc); end
				REG_CA: begin wc = -dot3(ap, ca); wa = dot3(cp, ca); end
				REG_VB: wb = 1;
				REG_VA: wa = 1;
				REG_VC: wc = 1;
				default: begin wa = 1; wb = 1; wc = 1; end
			endcase
			if (wa < 0) wa = 0;
			if (wb < 0) wb = 0;
			if (wc < 0) wc = 0;
			wsum = wa + wb + wc;
			if (wsum == 0) begin
				r.qx = in[0]; r.qy = in[1]; r.qz = in[2];
				r.degenerate = 1'b1;
			end else begin
				r.qx = mean_coord(wa, wb, wc, wsum, v[0][0], v[1][0], v[2][0]);
				r.qy = mean_coord(wa, wb, wc, wsum, v[0][1], v[1][1], v[2][1]);
				r.qz = mean_coord(wa, wb, wc, wsum, v[0][2], v[1][2], v[2][2]);
				r.degenerate = 1'b0;
			end
			pending.push_back(r);
		endfunction

		task check_result(input point_rsp_t got);
			point_rsp_t exp;
			if (pending.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			exp = pending.pop_front();
			if (got.qx !== exp.qx)
				report_mismatch($sformatf("qx got %0d want %0d", got.qx, exp.qx));
			if (got.qy !== exp.qy)
				report_mismatch($sformatf("qy got %0d want %0d", got.qy, exp.qy));
			if (got.qz !== exp.qz)
				report_mismatch($sformatf("qz got %0d want %0d", got.qz, exp.qz));
			if (got.region !== exp.region)
				report_mismatch($sformatf("region got %0d want %0d", got.region, exp.region));
			if (got.degenerate !== exp.degenerate)
				report_mismatch($sformatf("degenerate got %0b want %0b",
					got.degenerate, exp.degenerate));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	coord_t ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
	coord_t cx = '0, cy = '0, cz = '0, px = '0, py = '0, pz = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	coord_t qx, qy, qz;
	region_t region;
	logic degenerate;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycle_count = 0;
	nearest_point_board board = new();

	nearest_point_on_triangle #(.COORD_WIDTH(CW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.cx(cx), .cy(cy), .cz(cz), .px(px), .py(py), .pz(pz),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.qx(qx), .qy(qy), .qz(qz), .region(region), .degenerate(degenerate)
	);

	always #5 clk = ~clk;

	// Cycle limit guards against a hung pipeline.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stalls, and check every accepted result.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			board.check_result('{qx, qy, qz, region, degenerate});
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Send one request, holding it until the block takes it. Valid stays high
	// between back-to-back requests and drops only while the sender idles.
	task automatic send_request(input coord_t in[12]);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		{ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz} <=
			{in[0], in[1], in[2], in[3], in[4], in[5],
			 in[6], in[7], in[8], in[9], in[10], in[11]};
		do @(posedge clk); while (!req_ready);
		board.note_request(in);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return coord_t'($urandom_range(4095)) - 16'sd2048;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Mostly proper triangles of moderate size; sometimes fully random or flat.
	task automatic send_random();
		coord_t in[12];
		int mode;
		mode = $urandom_range(9);
		for (int i = 0; i < 12; i++) begin
			if (mode < 6) in[i] = coord_t'($urandom_range(16383)) - 16'sd8192;
			else in[i] = rand_coord();
		end
		if (mode == 9) begin
			// Collapse B onto A for a zero-length edge.
			for (int i = 0; i < 3; i++) in[3 + i] = in[i];
		end
		send_request(in);
	endtask

	task automatic send_directed();
		coord_t t[12];
		// Interior point, each edge side and each corner of a right triangle.
		coord_t pts[9][3] = '{'{1000, 1000, 300}, '{2000, -900, 0}, '{3000, 3000, -5},
			'{-900, 2000, 0}, '{-500, -500, 7}, '{5000, -300, 0}, '{-300, 5000, 0},
			'{0, 0, 0}, '{4096, 0, 0}};
		for (int k = 0; k < 9; k++) begin
			t = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0, pts[k][0], pts[k][1], pts[k][2]};
			send_request(t);
		end
		// Extremes: all max, all min, alternating corners.
		t = '{default: 16'sh7fff}; send_request(t);
		t = '{default: 16'sh8000}; send_request(t);
		t = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000};
		send_request(t);
		t = '{16'sh7fff, 0, 16'sh8000, 16'sh8000, 16'sh7fff, 0,
			0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
		send_request(t);
		// Flat collinear triangle and a single-point triangle.
		t = '{0, 0, 0, 100, 100, 100, 200, 200, 200, 5, -7, 3}; send_request(t);
		t = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, 1, 2, 3}; send_request(t);
		// Far query points that push the weighted mean toward saturation.
		t = '{16'sh8000, 16'sh8000, 0, 16'sh7fff, 16'sh8000, 0, 16'sh8000, 16'sh7fff, 0,
			16'sh7fff, 16'sh7fff, 16'sh7fff};
		send_request(t);
	endtask

	// Stop sending and wait until every outstanding result has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		// The sender holds off once until the pipeline has emptied.
		drain();
		send_idle_pct = 35; recv_idle_pct = 76;
		repeat (370) send_random();
		send_idle_pct = 76; recv_idle_pct = 35;
		repeat (370) send_random();
		send_idle_pct = 0; recv_idle_pct = 0;
		repeat (370) send_random();
		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0 && board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
